### hw/rtl/video_register_port_and_vram_map_defines.svh
// Assertion macros used by the video register port checker.
`ifndef VIDEO_REGISTER_PORT_AND_VRAM_MAP_DEFINES_SVH
`define VIDEO_REGISTER_PORT_AND_VRAM_MAP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define VRVM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent ends.
`define VRVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/vrvm_pkg.sv
// Codes and memory map constants of the video register port.
package vrvm_pkg;

    typedef logic [2:0] op_code_t;
    typedef logic [2:0] reg_code_t;
    typedef logic [1:0] mirror_code_t;

    localparam op_code_t OP_READ     = 3'd0;
    localparam op_code_t OP_PEEK     = 3'd1;
    localparam op_code_t OP_WRITE    = 3'd2;
    localparam op_code_t OP_VBLANK   = 3'd3;
    localparam op_code_t OP_PRERENDER = 3'd4;

    localparam reg_code_t REG_CONTROL  = 3'd0;
    localparam reg_code_t REG_MASK     = 3'd1;
    localparam reg_code_t REG_STATUS   = 3'd2;
    localparam reg_code_t REG_OAM_ADDR = 3'd3;
    localparam reg_code_t REG_OAM_DATA = 3'd4;
    localparam reg_code_t REG_SCROLL   = 3'd5;
    localparam reg_code_t REG_ADDRESS  = 3'd6;
    localparam reg_code_t REG_DATA     = 3'd7;

    localparam mirror_code_t MIR_VERTICAL   = 2'd0;
    localparam mirror_code_t MIR_HORIZONTAL = 2'd1;

    localparam int PATTERN_BYTES     = 8192;
    localparam int PATTERN_AW        = 13;
    localparam int SPRITE_ATTR_BYTES = 256;
    localparam int PALETTE_BYTES     = 32;

    localparam logic [13:0] PALETTE_BASE = 14'h3F00;
    localparam logic [7:0]  STATUS_FLAGS = 8'hE0;
    localparam logic [7:0]  VBLANK_FLAG  = 8'h80;
    localparam logic [7:0]  GRAY_MASK    = 8'h30;
    localparam logic [7:0]  COLOR_MASK   = 8'h3F;
    localparam logic [14:0] STEP_ROW     = 15'd32;
    localparam logic [14:0] STEP_BYTE    = 15'd1;

endpackage

### hw/rtl/video_register_port_and_vram_map.sv
// CPU register port of a tile video chip with its video memory map.
//
// Input channel (in_valid/in_ready): one word per bus access or frame event,
// carrying operation, reg_index and write_data. Output channel
// (out_valid/out_ready): one word per input, carrying read_data and
// nmi_request. cfg_we/cfg_wdata set the nametable mirroring mode.
//
// On acceptance the pattern, nametable and sprite memories are read into
// registers (synchronous read) beside the execute stage payload; the execute
// stage then executes the access and loads the output register. A new word
// is accepted every cycle while the output register drains; the address used
// for each memory read is forwarded from the access executing in the same
// cycle, and a read of an entry being written in that cycle takes the written byte.
//
// Reset clears the architectural and valid registers, the palette and the
// sprite memory valid bits (an unwritten sprite entry reads zero); pattern and
// nametable contents are undefined until written. No clearing pass is needed.
// When out_ready is low the result holds, the executing access waits behind
// it and in_ready drops while that access waits, until the output register drains.
module video_register_port_and_vram_map #(
    parameter int NAMETABLE_BYTES = 2048
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] operation,
    input  logic [2:0] reg_index,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       nmi_request
);

    localparam int NT_AW = $clog2(NAMETABLE_BYTES);

    function automatic logic [NT_AW-1:0] nt_index(input logic [11:0] off,
                                                   input logic [1:0] mir);
        logic page;
        page = (mir == vrvm_pkg::MIR_VERTICAL) ? off[10] : off[11];
        return NT_AW'({page, off[9:0]});
    endfunction

    function automatic logic [4:0] pal_index(input logic [4:0] a);
        logic [4:0] idx;
        idx = a;
        if (a[4] && (a[1:0] == 2'b00))
        begin
            idx = {1'b0, a[3:0]};
        end
        return idx;
    endfunction

    // architectural state
    logic [1:0]  mirroring_reg;
    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  status_reg, status_next;
    logic [14:0] cur_addr_reg, cur_addr_next;
    logic [14:0] tmp_addr_reg, tmp_addr_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  read_buffer_reg, read_buffer_next;
    logic [7:0]  sprite_addr_reg, sprite_addr_next;
    logic [7:0]  palette_reg [vrvm_pkg::PALETTE_BYTES];
    logic [vrvm_pkg::SPRITE_ATTR_BYTES-1:0] oam_valid_reg;

    logic [7:0] pattern_mem [vrvm_pkg::PATTERN_BYTES];
    logic [7:0] nt_mem [NAMETABLE_BYTES];
    logic [7:0] oam_mem [vrvm_pkg::SPRITE_ATTR_BYTES];

    // execute stage
    logic        ex_valid_reg;
    logic [2:0]  ex_op_reg;
    logic [2:0]  ex_idx_reg;
    logic [7:0]  ex_wdata_reg;
    logic [7:0]  pat_q_reg, nt_q_reg, oam_q_reg;
    logic        oam_v_reg;
    logic        pat_fwd_reg, nt_fwd_reg, oam_fwd_reg;

    // output stage
    logic        out_valid_reg;
    logic [7:0]  read_data_reg;
    logic        nmi_reg;

    logic        ex_fire, accept;
    logic [7:0]  rd_val;
    logic        nmi_val;
    logic        pat_we, nt_we, oam_we, pal_we;
    logic [vrvm_pkg::PATTERN_AW-1:0] pat_wa, pat_ra;
    logic [NT_AW-1:0] nt_wa, nt_ra;
    logic [7:0]  oam_ra;
    logic [4:0]  pal_idx;
    logic [13:0] a14;
    logic        nt_mapped;
    logic [7:0]  pat_val, nt_val, oam_val, vram_val;
    logic [14:0] cur_stepped;

    assign ex_fire  = ex_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !ex_valid_reg || ex_fire;
    assign accept   = in_valid && in_ready;

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign nmi_request = nmi_reg;

    assign nt_mapped = (mirroring_reg == vrvm_pkg::MIR_VERTICAL)
                    || (mirroring_reg == vrvm_pkg::MIR_HORIZONTAL);

    // read side uses the address left by the access executing now
    assign pat_ra = cur_addr_next[vrvm_pkg::PATTERN_AW-1:0];
    assign nt_ra  = nt_index(cur_addr_next[11:0], mirroring_reg);
    assign oam_ra = sprite_addr_next;

    assign a14     = cur_addr_reg[13:0];
    assign pat_wa  = cur_addr_reg[vrvm_pkg::PATTERN_AW-1:0];
    assign nt_wa   = nt_index(cur_addr_reg[11:0], mirroring_reg);
    assign pal_idx = pal_index(cur_addr_reg[4:0]);

    assign pat_val = pat_fwd_reg ? ex_wdata_reg : pat_q_reg;
    assign nt_val  = nt_fwd_reg ? ex_wdata_reg : nt_q_reg;
    assign oam_val = oam_fwd_reg ? ex_wdata_reg : (oam_v_reg ? oam_q_reg : 8'h00);

    assign cur_stepped = cur_addr_reg
                       + (control_reg[2] ? vrvm_pkg::STEP_ROW : vrvm_pkg::STEP_BYTE);

    always_comb
    begin
        if (!a14[13])
        begin
            vram_val = pat_val;
        end
        else if (a14 < vrvm_pkg::PALETTE_BASE)
        begin
            vram_val = nt_mapped ? nt_val : 8'h00;
        end
        else
        begin
            vram_val = palette_reg[pal_idx]
                     & (mask_reg[0] ? vrvm_pkg::GRAY_MASK : vrvm_pkg::COLOR_MASK);
        end
    end

    always_comb
    begin
        control_next     = control_reg;
        mask_next        = mask_reg;
        status_next      = status_reg;
        cur_addr_next    = cur_addr_reg;
        tmp_addr_next    = tmp_addr_reg;
        fine_x_next      = fine_x_reg;
        toggle_next      = toggle_reg;
        read_buffer_next = read_buffer_reg;
        sprite_addr_next = sprite_addr_reg;
        rd_val           = 8'h00;
        nmi_val          = 1'b0;
        pat_we           = 1'b0;
        nt_we            = 1'b0;
        oam_we           = 1'b0;
        pal_we           = 1'b0;
        if (ex_fire)
        begin
            case (ex_op_reg)
                vrvm_pkg::OP_READ:
                begin
                    case (ex_idx_reg)
                        vrvm_pkg::REG_STATUS:
                        begin
                            rd_val = (status_reg & vrvm_pkg::STATUS_FLAGS)
                                   | (read_buffer_reg & ~vrvm_pkg::STATUS_FLAGS);
                            status_next = status_reg & ~vrvm_pkg::VBLANK_FLAG;
                            toggle_next = 1'b0;
                        end
                        vrvm_pkg::REG_OAM_DATA:
                        begin
                            rd_val = oam_val;
                        end
                        vrvm_pkg::REG_DATA:
                        begin
                            // palette reads bypass the buffer
                            rd_val = (a14 >= vrvm_pkg::PALETTE_BASE) ? vram_val
                                                                     : read_buffer_reg;
                            read_buffer_next = vram_val;
                            cur_addr_next    = cur_stepped;
                        end
                        default:
                        begin
                            rd_val = 8'h00;
                        end
                    endcase
                end
                vrvm_pkg::OP_PEEK:
                begin
                    case (ex_idx_reg)
                        vrvm_pkg::REG_CONTROL: rd_val = control_reg;
                        vrvm_pkg::REG_MASK:    rd_val = mask_reg;
                        vrvm_pkg::REG_STATUS:  rd_val = status_reg;
                        default:               rd_val = 8'h00;
                    endcase
                end
                vrvm_pkg::OP_WRITE:
                begin
                    case (ex_idx_reg)
                        vrvm_pkg::REG_CONTROL:
                        begin
                            control_next  = ex_wdata_reg;
                            tmp_addr_next = {tmp_addr_reg[14:12], ex_wdata_reg[1:0],
                                             tmp_addr_reg[9:0]};
                        end
                        vrvm_pkg::REG_MASK:
                        begin
                            mask_next = ex_wdata_reg;
                        end
                        vrvm_pkg::REG_OAM_ADDR:
                        begin
                            sprite_addr_next = ex_wdata_reg;
                        end
                        vrvm_pkg::REG_OAM_DATA:
                        begin
                            oam_we           = 1'b1;
                            sprite_addr_next = sprite_addr_reg + 8'd1;
                        end
                        vrvm_pkg::REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                fine_x_next   = ex_wdata_reg[2:0];
                                tmp_addr_next = {tmp_addr_reg[14:5], ex_wdata_reg[7:3]};
                                toggle_next   = 1'b1;
                            end
                            else
                            begin
                                tmp_addr_next = {ex_wdata_reg[2:0], tmp_addr_reg[11:10],
                                                 ex_wdata_reg[7:3], tmp_addr_reg[4:0]};
                                toggle_next   = 1'b0;
                            end
                        end
                        vrvm_pkg::REG_ADDRESS:
                        begin
                            if (!toggle_reg)
                            begin
                                tmp_addr_next = {1'b0, ex_wdata_reg[5:0], tmp_addr_reg[7:0]};
                                toggle_next   = 1'b1;
                            end
                            else
                            begin
                                tmp_addr_next = {tmp_addr_reg[14:8], ex_wdata_reg};
                                cur_addr_next = {tmp_addr_reg[14:8], ex_wdata_reg};
                                toggle_next   = 1'b0;
                            end
                        end
                        vrvm_pkg::REG_DATA:
                        begin
                            if (!a14[13])
                            begin
                                pat_we = 1'b1;
                            end
                            else if (a14 < vrvm_pkg::PALETTE_BASE)
                            begin
                                nt_we = nt_mapped;
                            end
                            else
                            begin
                                pal_we = 1'b1;
                            end
                            cur_addr_next = cur_stepped;
                        end
                        default:
                        begin
                            // status is read-only
                            rd_val = 8'h00;
                        end
                    endcase
                end
                vrvm_pkg::OP_VBLANK:
                begin
                    status_next = status_reg | vrvm_pkg::VBLANK_FLAG;
                    nmi_val     = control_reg[7];
                end
                vrvm_pkg::OP_PRERENDER:
                begin
                    status_next = status_reg & ~vrvm_pkg::STATUS_FLAGS;
                end
                default:
                begin
                    rd_val = 8'h00;
                end
            endcase
        end
    end

    // memories: one write from execute, one registered read at accept
    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pattern_mem[pat_wa] <= ex_wdata_reg;
        end
        if (accept)
        begin
            pat_q_reg   <= pattern_mem[pat_ra];
            pat_fwd_reg <= pat_we && (pat_wa == pat_ra);
        end
    end

    always_ff @(posedge clk)
    begin
        if (nt_we)
        begin
            nt_mem[nt_wa] <= ex_wdata_reg;
        end
        if (accept)
        begin
            nt_q_reg   <= nt_mem[nt_ra];
            nt_fwd_reg <= nt_we && (nt_wa == nt_ra);
        end
    end

    always_ff @(posedge clk)
    begin
        if (oam_we)
        begin
            oam_mem[sprite_addr_reg] <= ex_wdata_reg;
        end
        if (accept)
        begin
            oam_q_reg   <= oam_mem[oam_ra];
            oam_v_reg   <= oam_valid_reg[oam_ra];
            oam_fwd_reg <= oam_we && (sprite_addr_reg == oam_ra);
        end
    end

    // execute stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_op_reg    <= operation;
            ex_idx_reg   <= reg_index;
            ex_wdata_reg <= write_data;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (ex_fire)
        begin
            read_data_reg <= rd_val;
            nmi_reg       <= nmi_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirroring_reg   <= vrvm_pkg::MIR_VERTICAL;
            control_reg     <= 8'h00;
            mask_reg        <= 8'h00;
            status_reg      <= 8'h00;
            cur_addr_reg    <= 15'h0000;
            tmp_addr_reg    <= 15'h0000;
            fine_x_reg      <= 3'd0;
            toggle_reg      <= 1'b0;
            read_buffer_reg <= 8'h00;
            sprite_addr_reg <= 8'h00;
            oam_valid_reg   <= '0;
            for (int i = 0; i < vrvm_pkg::PALETTE_BYTES; i++)
            begin
                palette_reg[i] <= 8'h00;
            end
            ex_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mirroring_reg <= cfg_wdata;
            end
            control_reg     <= control_next;
            mask_reg        <= mask_next;
            status_reg      <= status_next;
            cur_addr_reg    <= cur_addr_next;
            tmp_addr_reg    <= tmp_addr_next;
            fine_x_reg      <= fine_x_next;
            toggle_reg      <= toggle_next;
            read_buffer_reg <= read_buffer_next;
            sprite_addr_reg <= sprite_addr_next;
            if (oam_we)
            begin
                oam_valid_reg[sprite_addr_reg] <= 1'b1;
            end
            if (pal_we)
            begin
                palette_reg[pal_idx] <= ex_wdata_reg;
            end
            if (accept)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (ex_fire)
            begin
                ex_valid_reg <= 1'b0;
            end
            // hold a stalled word, drop it once taken
            if (ex_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/vrvm_checker.sv
// Port-level checker for the video register port, bound to the top level.
`include "video_register_port_and_vram_map_defines.svh"

module vrvm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [2:0] operation,
    input logic [2:0] reg_index,
    input logic [7:0] write_data,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_data,
    input logic       nmi_request
);

    logic [8:0]  out_word;
    logic [13:0] in_word;

    assign out_word = {read_data, nmi_request};
    assign in_word  = {operation, reg_index, write_data};

    // a stalled result keeps its value
    `VRVM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_word), "stalled result changed")

    // an accepted word reaches the output once the output register can take it
    `VRVM_ASSERT_NEXT(a_latency, clk, rst_n,
        (in_valid && in_ready) ##1 (!out_valid || out_ready), out_valid,
        "result missing two cycles after accept")

    // input backpressure only comes from a full output register
    `VRVM_ASSERT_NOW(a_ready_cause, clk, rst_n, !in_ready, out_valid,
        "in_ready low with output empty")

    // frame events never return data
    `VRVM_ASSERT_NOW(a_nmi_no_data, clk, rst_n, out_valid && nmi_request,
        read_data == 8'h00, "nmi result carries data")

    // an offered word carries known fields
    `VRVM_ASSERT_NOW(a_in_known, clk, rst_n, in_valid, !$isunknown(in_word),
        "unknown input word")

endmodule

bind video_register_port_and_vram_map vrvm_checker u_vrvm_checker (.*);

### bench/tb_video_register_port_and_vram_map.sv
// Self-checking bench for the video register port: predicted replies vs. the block's results.
module tb_video_register_port_and_vram_map;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT_BYTES        = 2048;
    localparam int ITEMS_PER_PHASE = 158;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASES          = 6;

    localparam vrvm_pkg::mirror_code_t MIR_UNMAPPED    = 2'd2;
    localparam vrvm_pkg::mirror_code_t MIR_UNMAPPED_HI = 2'd3;
    localparam vrvm_pkg::op_code_t     OP_UNUSED_LO    = 3'd5;
    localparam vrvm_pkg::op_code_t     OP_UNUSED_HI    = 3'd7;

    localparam vrvm_pkg::mirror_code_t MIRROR_PLAN [PHASES] = '{
        vrvm_pkg::MIR_HORIZONTAL, vrvm_pkg::MIR_VERTICAL, MIR_UNMAPPED,
        vrvm_pkg::MIR_HORIZONTAL, MIR_UNMAPPED_HI, vrvm_pkg::MIR_VERTICAL};

    typedef struct packed {
        vrvm_pkg::op_code_t  op;
        vrvm_pkg::reg_code_t sel;
        logic [7:0]          wdata;
    } bus_access_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       nmi;
    } bus_reply_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_wdata = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] operation = '0;
    logic [2:0] reg_index = '0;
    logic [7:0] write_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;
    logic       nmi_request;

    bus_access_t bus_accesses [$];
    bus_reply_t  expected_replies [$];

    // shadow of the port state, advanced as words are queued
    vrvm_pkg::mirror_code_t mirror_mode = vrvm_pkg::MIR_VERTICAL;
    bit [7:0]  ctrl_q, mask_q, status_q, rbuf_q, oam_ptr;
    bit [14:0] vaddr_q, taddr_q;
    bit        toggle_q;
    bit [7:0]  oam_mem [vrvm_pkg::SPRITE_ATTR_BYTES];
    bit [7:0]  pal_mem [vrvm_pkg::PALETTE_BYTES];
    logic [7:0] pat_mem [vrvm_pkg::PATTERN_BYTES];
    logic [7:0] nt_mem [NT_BYTES];
    bit        pat_written [vrvm_pkg::PATTERN_BYTES];
    bit        nt_written [NT_BYTES];

    int queued_count = 0;
    int accepted_count = 0;
    int result_count = 0;
    int fail_count = 0;
    int data_reads = 0;
    int bypass_reads = 0;
    int nmi_count = 0;
    int idle_cycles = 0;

    video_register_port_and_vram_map #(
        .NAMETABLE_BYTES(NT_BYTES)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .reg_index  (reg_index),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .nmi_request(nmi_request)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int nt_slot(logic [11:0] off);
        logic page;
        if (mirror_mode == vrvm_pkg::MIR_VERTICAL)
            page = off[10];
        else if (mirror_mode == vrvm_pkg::MIR_HORIZONTAL)
            page = off[11];
        else
            return -1;
        return int'({page, off[9:0]}) % NT_BYTES;
    endfunction

    // backdrop entries of the sprite palettes fold onto the background ones
    function automatic logic [4:0] pal_slot(logic [4:0] a);
        if ((a & 5'h13) == 5'h10)
            return a - 5'h10;
        return a;
    endfunction

    function automatic logic [7:0] vram_fetch(logic [14:0] a);
        logic [13:0] a14;
        int slot;
        a14 = a[13:0];
        if (a14 < vrvm_pkg::PATTERN_BYTES)
            return pat_mem[a14[12:0]];
        if (a14 < vrvm_pkg::PALETTE_BASE)
        begin
            slot = nt_slot(a14[11:0]);
            return (slot < 0) ? 8'h00 : nt_mem[slot];
        end
        return pal_mem[pal_slot(a14[4:0])]
             & (mask_q[0] ? vrvm_pkg::GRAY_MASK : vrvm_pkg::COLOR_MASK);
    endfunction

    function automatic void vram_store(logic [14:0] a, logic [7:0] d);
        logic [13:0] a14;
        int slot;
        a14 = a[13:0];
        if (a14 < vrvm_pkg::PATTERN_BYTES)
        begin
            pat_mem[a14[12:0]] = d;
            pat_written[a14[12:0]] = 1'b1;
        end
        else if (a14 < vrvm_pkg::PALETTE_BASE)
        begin
            slot = nt_slot(a14[11:0]);
            if (slot >= 0)
            begin
                nt_mem[slot] = d;
                nt_written[slot] = 1'b1;
            end
        end
        else
            pal_mem[pal_slot(a14[4:0])] = d;
    endfunction

    function automatic bit fetch_defined();
        logic [13:0] a14;
        int slot;
        a14 = vaddr_q[13:0];
        if (a14 < vrvm_pkg::PATTERN_BYTES)
            return pat_written[a14[12:0]];
        if (a14 < vrvm_pkg::PALETTE_BASE)
        begin
            slot = nt_slot(a14[11:0]);
            return (slot < 0) || nt_written[slot];
        end
        return 1'b1;
    endfunction

    function automatic void advance_vaddr();
        vaddr_q = vaddr_q + (ctrl_q[2] ? vrvm_pkg::STEP_ROW : vrvm_pkg::STEP_BYTE);
    endfunction

    function automatic bus_reply_t apply_access(bus_access_t acc);
        bus_reply_t r;
        logic [7:0] d;
        r = '0;
        d = acc.wdata;
        case (acc.op)
            vrvm_pkg::OP_READ:
            begin
                if (acc.sel == vrvm_pkg::REG_STATUS)
                begin
                    r.rd = (status_q & vrvm_pkg::STATUS_FLAGS)
                         | (rbuf_q & ~vrvm_pkg::STATUS_FLAGS);
                    status_q = status_q & ~vrvm_pkg::VBLANK_FLAG;
                    toggle_q = 1'b0;
                end
                else if (acc.sel == vrvm_pkg::REG_OAM_DATA)
                    r.rd = oam_mem[oam_ptr];
                else if (acc.sel == vrvm_pkg::REG_DATA)
                begin
                    data_reads++;
                    r.rd = rbuf_q;
                    rbuf_q = vram_fetch(vaddr_q);
                    if (vaddr_q[13:0] >= vrvm_pkg::PALETTE_BASE)
                    begin
                        r.rd = rbuf_q;
                        bypass_reads++;
                    end
                    advance_vaddr();
                end
            end
            vrvm_pkg::OP_PEEK:
            begin
                if (acc.sel == vrvm_pkg::REG_CONTROL)
                    r.rd = ctrl_q;
                else if (acc.sel == vrvm_pkg::REG_MASK)
                    r.rd = mask_q;
                else if (acc.sel == vrvm_pkg::REG_STATUS)
                    r.rd = status_q;
            end
            vrvm_pkg::OP_WRITE:
            begin
                case (acc.sel)
                    vrvm_pkg::REG_CONTROL:
                    begin
                        ctrl_q = d;
                        taddr_q[11:10] = d[1:0];
                    end
                    vrvm_pkg::REG_MASK: mask_q = d;
                    vrvm_pkg::REG_OAM_ADDR: oam_ptr = d;
                    vrvm_pkg::REG_OAM_DATA:
                    begin
                        oam_mem[oam_ptr] = d;
                        oam_ptr = oam_ptr + 8'd1;
                    end
                    vrvm_pkg::REG_SCROLL:
                    begin
                        if (!toggle_q)
                            taddr_q[4:0] = d[7:3];
                        else
                        begin
                            taddr_q[14:12] = d[2:0];
                            taddr_q[9:5] = d[7:3];
                        end
                        toggle_q = !toggle_q;
                    end
                    vrvm_pkg::REG_ADDRESS:
                    begin
                        if (!toggle_q)
                            taddr_q = {1'b0, d[5:0], taddr_q[7:0]};
                        else
                        begin
                            taddr_q[7:0] = d;
                            vaddr_q = taddr_q;
                        end
                        toggle_q = !toggle_q;
                    end
                    vrvm_pkg::REG_DATA:
                    begin
                        vram_store(vaddr_q, d);
                        advance_vaddr();
                    end
                    default: ;
                endcase
            end
            vrvm_pkg::OP_VBLANK:
            begin
                status_q = status_q | vrvm_pkg::VBLANK_FLAG;
                r.nmi = ctrl_q[7];
                nmi_count += ctrl_q[7];
            end
            vrvm_pkg::OP_PRERENDER: status_q = status_q & ~vrvm_pkg::STATUS_FLAGS;
            default: ;
        endcase
        return r;
    endfunction

    function automatic void push_access(vrvm_pkg::op_code_t op, vrvm_pkg::reg_code_t sel,
                                        logic [7:0] d);
        bus_access_t acc;
        acc.op = op;
        acc.sel = sel;
        acc.wdata = d;
        // turn a data read of a never-written byte into a store of the same word
        if (op == vrvm_pkg::OP_READ && sel == vrvm_pkg::REG_DATA && !fetch_defined())
            acc.op = vrvm_pkg::OP_WRITE;
        bus_accesses.push_back(acc);
        expected_replies.push_back(apply_access(acc));
        queued_count++;
    endfunction

    function automatic void point_at(logic [13:0] a);
        push_access(vrvm_pkg::OP_READ, vrvm_pkg::REG_STATUS, 8'($urandom));
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_ADDRESS, {2'($urandom), a[13:8]});
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_ADDRESS, a[7:0]);
    endfunction

    function automatic logic [13:0] pick_vram_target();
        case ($urandom_range(0, 4))
            0: return 14'($urandom_range(0, vrvm_pkg::PATTERN_BYTES - 1));
            1, 2: return 14'($urandom_range(16'h2000, 16'h3EFF));
            3: return vrvm_pkg::PALETTE_BASE | 14'($urandom_range(0, 255));
            // near the top: runs wrap back into pattern memory
            default: return 14'($urandom_range(16'h3FE0, 16'h3FFF));
        endcase
    endfunction

    // pick another address that should land on the same byte
    function automatic logic [13:0] mirror_alias(logic [13:0] a);
        logic [13:0] flip;
        if (a >= vrvm_pkg::PATTERN_BYTES && a < vrvm_pkg::PALETTE_BASE)
        begin
            flip = (mirror_mode == vrvm_pkg::MIR_HORIZONTAL) ? 14'h0400 : 14'h0800;
            if ($urandom_range(0, 1))
                a = a ^ flip;
            if ($urandom_range(0, 1))
                a = a ^ 14'h1000;
        end
        else if (a >= vrvm_pkg::PALETTE_BASE)
            a = a ^ {6'b0, 3'($urandom), (a[1:0] == 2'b00) ? 1'($urandom) : 1'b0, 4'b0};
        return a;
    endfunction

    function automatic void directed_checks();
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_CONTROL, 8'h84);
        push_access(vrvm_pkg::OP_VBLANK, vrvm_pkg::REG_CONTROL, 8'h00);
        push_access(vrvm_pkg::OP_PEEK, vrvm_pkg::REG_STATUS, 8'h00);
        push_access(vrvm_pkg::OP_READ, vrvm_pkg::REG_STATUS, 8'hFF);
        push_access(vrvm_pkg::OP_PEEK, vrvm_pkg::REG_STATUS, 8'h00);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_STATUS, 8'hFF);
        push_access(vrvm_pkg::OP_VBLANK, vrvm_pkg::REG_DATA, 8'hFF);
        push_access(vrvm_pkg::OP_PRERENDER, vrvm_pkg::REG_STATUS, 8'h00);
        push_access(vrvm_pkg::OP_PEEK, vrvm_pkg::REG_STATUS, 8'h00);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_MASK, 8'h01);
        push_access(vrvm_pkg::OP_PEEK, vrvm_pkg::REG_MASK, 8'h00);
        push_access(vrvm_pkg::OP_PEEK, vrvm_pkg::REG_CONTROL, 8'h00);
        push_access(vrvm_pkg::OP_PEEK, vrvm_pkg::REG_DATA, 8'h00);
        // store through a backdrop mirror, read back grayscale with bypass
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_ADDRESS, 8'hFF);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_ADDRESS, 8'h10);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_DATA, 8'hFF);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_ADDRESS, 8'h3F);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_ADDRESS, 8'h00);
        push_access(vrvm_pkg::OP_READ, vrvm_pkg::REG_DATA, 8'h00);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_OAM_ADDR, 8'hFF);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_OAM_DATA, 8'hA5);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_OAM_ADDR, 8'hFF);
        push_access(vrvm_pkg::OP_READ, vrvm_pkg::REG_OAM_DATA, 8'h00);
        // build address 0x7FFF through the scroll latch, then wrap past it
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_CONTROL, 8'h00);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_ADDRESS, 8'h3F);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_SCROLL, 8'hFF);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_SCROLL, 8'hF8);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_ADDRESS, 8'hFF);
        push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_DATA, 8'h5A);
        push_access(OP_UNUSED_HI, vrvm_pkg::REG_DATA, 8'hFF);
        push_access(OP_UNUSED_LO, vrvm_pkg::REG_CONTROL, 8'h00);
    endfunction

    function automatic void random_sequence();
        int kind;
        int n;
        logic [13:0] base;
        logic [7:0] spr;
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            if ($urandom_range(0, 1))
                push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_CONTROL, 8'($urandom));
            base = pick_vram_target();
            n = $urandom_range(1, 6);
            point_at(base);
            repeat (n) push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_DATA, 8'($urandom));
            point_at(mirror_alias(base));
            repeat (n + 1) push_access(vrvm_pkg::OP_READ, vrvm_pkg::REG_DATA, 8'($urandom));
        end
        else if (kind < 50)
        begin
            spr = 8'($urandom);
            n = $urandom_range(1, 6);
            push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_OAM_ADDR, spr);
            repeat (n)
                push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_OAM_DATA, 8'($urandom));
            push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_OAM_ADDR, spr);
            for (int i = 0; i < n; i++)
            begin
                push_access(vrvm_pkg::OP_READ, vrvm_pkg::REG_OAM_DATA, 8'($urandom));
                if ($urandom_range(0, 1))
                    push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_OAM_DATA, 8'($urandom));
                else
                    push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_OAM_ADDR, spr + 8'(i + 1));
            end
        end
        else if (kind < 60)
        begin
            if ($urandom_range(0, 1))
                push_access(vrvm_pkg::OP_READ, vrvm_pkg::REG_STATUS, 8'($urandom));
            push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_SCROLL, 8'($urandom));
            push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_SCROLL, 8'($urandom));
            if ($urandom_range(0, 2) == 0)
            begin
                // load the current address straight from the scroll latch when the write toggle starts clear
                push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_SCROLL, 8'($urandom));
                push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_ADDRESS, 8'($urandom));
                push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_DATA, 8'($urandom));
                push_access(vrvm_pkg::OP_READ, vrvm_pkg::REG_DATA, 8'($urandom));
            end
        end
        else if (kind < 70)
        begin
            push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_CONTROL, 8'($urandom));
            push_access(vrvm_pkg::OP_VBLANK, vrvm_pkg::reg_code_t'($urandom), 8'($urandom));
            push_access(vrvm_pkg::OP_PEEK, vrvm_pkg::REG_STATUS, 8'($urandom));
            if ($urandom_range(0, 1))
                push_access(vrvm_pkg::OP_READ, vrvm_pkg::REG_STATUS, 8'($urandom));
            push_access(vrvm_pkg::OP_PRERENDER, vrvm_pkg::reg_code_t'($urandom),
                        8'($urandom));
            push_access(vrvm_pkg::OP_PEEK, vrvm_pkg::REG_STATUS, 8'($urandom));
        end
        else if (kind < 80)
        begin
            push_access(vrvm_pkg::OP_WRITE,
                        $urandom_range(0, 1) ? vrvm_pkg::REG_MASK : vrvm_pkg::REG_CONTROL,
                        8'($urandom));
            if ($urandom_range(0, 3) == 0)
                push_access(vrvm_pkg::OP_WRITE, vrvm_pkg::REG_STATUS, 8'($urandom));
            repeat ($urandom_range(1, 3))
                push_access(vrvm_pkg::OP_PEEK, vrvm_pkg::reg_code_t'($urandom),
                            8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                push_access(vrvm_pkg::op_code_t'($urandom_range(0, 7)),
                            vrvm_pkg::reg_code_t'($urandom), 8'($urandom));
        end
    endfunction

    task automatic write_mirroring(vrvm_pkg::mirror_code_t m);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        mirror_mode = m;
    endtask

    task automatic drain();
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // sender: bursts of words with random gaps
    int burst_left;
    int gap_left;
    bus_access_t next_word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            operation <= vrvm_pkg::OP_READ;
            reg_index <= vrvm_pkg::REG_CONTROL;
            write_data <= '0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                accepted_count++;
            // hold a word that has not been taken yet
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (bus_accesses.size() > 0)
                begin
                    next_word = bus_accesses.pop_front();
                    in_valid <= 1'b1;
                    operation <= next_word.op;
                    reg_index <= next_word.sel;
                    write_data <= next_word.wdata;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall on a 16-bit pattern of ready bits, redrawn each time it runs out
    logic [15:0] stall_bits;
    int stall_pos;
    bus_reply_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_bits = 16'hFFFF;
            stall_pos = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected result word: read_data %02h nmi_request %0b",
                           read_data, nmi_request);
                    fail_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    result_count++;
                    if (read_data !== want.rd)
                    begin
                        $error("read_data: expected %02h, got %02h", want.rd, read_data);
                        fail_count++;
                    end
                    if (nmi_request !== want.nmi)
                    begin
                        $error("nmi_request: expected %0b, got %0b", want.nmi, nmi_request);
                        fail_count++;
                    end
                end
            end
            out_ready <= stall_bits[stall_pos];
            stall_pos++;
            if (stall_pos == 16)
            begin
                stall_pos = 0;
                case ($urandom_range(0, 3))
                    0: stall_bits = 16'hFFFF;
                    1: stall_bits = 16'($urandom);
                    2: stall_bits = 16'($urandom) | 16'($urandom);
                    default: stall_bits = (16'($urandom) & 16'($urandom)) | 16'h0001;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int phase_end;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            write_mirroring(MIRROR_PLAN[p]);
            if (p == 0)
                directed_checks();
            phase_end = (p + 1) * ITEMS_PER_PHASE;
            while (queued_count < phase_end)
                random_sequence();
            drain();
        end
        $display("Ran %0d words (%0d results checked) across %0d mirroring settings",
                 accepted_count, result_count, PHASES);
        $display("VRAM data reads %0d, palette bypass reads %0d, NMI requests %0d",
                 data_reads, bypass_reads, nmi_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
